[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the text renderer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every edge outside reset
`define ASSERT_IMPL(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) cond) else $error("%m failed");
// property checked even during reset
`define ASSERT_ALWAYS(label, clk, cond) \
   label: assert property (@(posedge clk) cond) else $error("%m failed");
`endif

[hw/rtl/otcr_pkg.sv]
// ---------------------------------------------------------------------------
// otcr_pkg
// Types, constants and glyph ROM of the text column renderer.
// ---------------------------------------------------------------------------
package otcr_pkg;

   localparam int GLYPH_COUNT_DEF = 159;
   localparam int LAST_COLUMN_DEF = 127;
   localparam int LAST_PAGE_DEF   = 7;
   localparam int ROM_WORDS       = 159;

   localparam logic [1:0] MODE_CHAR   = 2'd0;
   localparam logic [1:0] MODE_CURSOR = 2'd1;
   localparam logic [1:0] MODE_INVERT = 2'd2;

   localparam logic [1:0] CSR_WIDTH_SCALE   = 2'd0;
   localparam logic [1:0] CSR_DOUBLE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_AUTO_NEWLINE  = 2'd2;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_WINDOW = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_COLUMN,
      ST_SPACER,
      ST_WINDOW
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_item;
      logic load_glyph;
      logic emit_column;
      logic emit_spacer;
      logic emit_window;
      logic next_rep;
      logic next_col;
      logic next_spacer;
      logic do_newline;
      logic do_skip;
      logic do_flip;
      logic do_cursor;
      logic do_invert;
      logic finish_glyph;
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_NEWLINE,
      ACT_FLIP,
      ACT_SKIP,
      ACT_DRAW,
      ACT_CURSOR,
      ACT_INVERT
   } action_type;

   // datapath -> controller
   typedef struct packed {
      action_type action;
      logic       rep_last;
      logic       half_last;
      logic       col_last;
      logic       spacer_last;
   } status_type;

   function automatic logic [31:0] glyph_rom(input logic [7:0] idx);
      logic [31:0] w;
      case (idx)
         8'd0: w = 32'h00000000; 8'd1: w = 32'h00000df7; 8'd2: w = 32'h40007007;
         8'd3: w = 32'hd2fd2fd2; 8'd4: w = 32'hc60dec18; 8'd5: w = 32'hf1c8c4e3;
         8'd6: w = 32'he06e59b8; 8'd7: w = 32'h00000007; 8'd8: w = 32'h4002185e;
         8'd9: w = 32'h4001e861; 8'd10: w = 32'h40014214; 8'd11: w = 32'h40008708;
         8'd12: w = 32'h00000638; 8'd13: w = 32'h40008208; 8'd14: w = 32'h00000618;
         8'd15: w = 32'h40003330; 8'd16: w = 32'hde86d85e; 8'd17: w = 32'h8083f880;
         8'd18: w = 32'he6a69a72; 8'd19: w = 32'hda965852; 8'd20: w = 32'hd0fd2518;
         8'd21: w = 32'hd9965963; 8'd22: w = 32'hd0a69a9c; 8'd23: w = 32'hc3159841;
         8'd24: w = 32'hda96595a; 8'd25: w = 32'hdea69a46; 8'd26: w = 32'h000006db;
         8'd27: w = 32'h000006fb; 8'd28: w = 32'h40011284; 8'd29: w = 32'h8028a28a;
         8'd30: w = 32'h40004291; 8'd31: w = 32'hc7165b41; 8'd32: w = 32'hefa6d87f;
         8'd33: w = 32'hfe24927e; 8'd34: w = 32'hfa96597f; 8'd35: w = 32'hd286185e;
         8'd36: w = 32'hde86187f; 8'd37: w = 32'he186597f; 8'd38: w = 32'hc114517f;
         8'd39: w = 32'hd8a6985e; 8'd40: w = 32'hff20823f; 8'd41: w = 32'h40021fe1;
         8'd42: w = 32'h4003d870; 8'd43: w = 32'hf128413f; 8'd44: w = 32'he082083f;
         8'd45: w = 32'hff0840bf; 8'd46: w = 32'hff2040bf; 8'd47: w = 32'hde86185e;
         8'd48: w = 32'hc624927f; 8'd49: w = 32'hee46985e; 8'd50: w = 32'hf624927f;
         8'd51: w = 32'hd2a69952; 8'd52: w = 32'hc107f041; 8'd53: w = 32'hdf82081f;
         8'd54: w = 32'hc7620607; 8'd55: w = 32'hdf81c81f; 8'd56: w = 32'hf12842b1;
         8'd57: w = 32'hc3138103; 8'd58: w = 32'he3965a71; 8'd59: w = 32'h4002187f;
         8'd60: w = 32'h40030303; 8'd61: w = 32'h4003f861; 8'd62: w = 32'hc4081084;
         8'd63: w = 32'hc4210204; 8'd64: w = 32'h40004081; 8'd65: w = 32'hdcaaaa90;
         8'd66: w = 32'hd892493f; 8'd67: w = 32'hd48a289c; 8'd68: w = 32'hff924918;
         8'd69: w = 32'hccaaaa9c; 8'd70: w = 32'h8027e200; 8'd71: w = 32'hdcaaaa84;
         8'd72: w = 32'hf810413f; 8'd73: w = 32'h00000f40; 8'd74: w = 32'h00000760;
         8'd75: w = 32'he250823f; 8'd76: w = 32'h0000081f; 8'd77: w = 32'hfc0bc0be;
         8'd78: w = 32'hfc0820be; 8'd79: w = 32'hdc8a289c; 8'd80: w = 32'hc428a2bc;
         8'd81: w = 32'hfc28a284; 8'd82: w = 32'hc210423e; 8'd83: w = 32'hd2aaaaa4;
         8'd84: w = 32'h400247c4; 8'd85: w = 32'hde82081e; 8'd86: w = 32'hce42040e;
         8'd87: w = 32'hde81881e; 8'd88: w = 32'he2508522; 8'd89: w = 32'hdea28a06;
         8'd90: w = 32'he6aaaab2; 8'd91: w = 32'h40021ccc; 8'd92: w = 32'h00000fc0;
         8'd93: w = 32'h4000cce1; 8'd94: w = 32'h80108108; 8'd95: w = 32'hf85915b8;
         8'd96: w = 32'hf996597f; 8'd97: w = 32'hfa96597f; 8'd98: w = 32'hc104107f;
         8'd99: w = 32'hf07d17b0; 8'd100: w = 32'hf3869a7f; 8'd101: w = 32'hfb11e13b;
         8'd102: w = 32'hda961852; 8'd103: w = 32'hff08423f; 8'd104: w = 32'hff10943f;
         8'd105: w = 32'hf128413f; 8'd106: w = 32'hff042330; 8'd107: w = 32'hff0840bf;
         8'd108: w = 32'hff10413f; 8'd109: w = 32'hde86185e; 8'd110: w = 32'hff04107f;
         8'd111: w = 32'hc624927f; 8'd112: w = 32'hd286185e; 8'd113: w = 32'hc107f041;
         8'd114: w = 32'hdf924903; 8'd115: w = 32'hde4bf49e; 8'd116: w = 32'hf12842b1;
         8'd117: w = 32'hff41041f; 8'd118: w = 32'hff104103; 8'd119: w = 32'hff83e83f;
         8'd120: w = 32'hff41e41f; 8'd121: w = 32'hd8924fc1; 8'd122: w = 32'hff62493f;
         8'd123: w = 32'hd892493f; 8'd124: w = 32'hde965852; 8'd125: w = 32'hff87f23f;
         8'd126: w = 32'hff249276; 8'd127: w = 32'hfcaaaa90; 8'd128: w = 32'hd0a69a9c;
         8'd129: w = 32'hf4aaaabe; 8'd130: w = 32'hc20820be; 8'd131: w = 32'hdcaa9a50;
         8'd132: w = 32'hccaaaa9c; 8'd133: w = 32'hf621c236; 8'd134: w = 32'hd4aaa894;
         8'd135: w = 32'hfe10843e; 8'd136: w = 32'hfe10943e; 8'd137: w = 32'he250823e;
         8'd138: w = 32'hf0302330; 8'd139: w = 32'hfe10813e; 8'd140: w = 32'hfe20823e;
         8'd141: w = 32'hdc8a289c; 8'd142: w = 32'hfe0820be; 8'd143: w = 32'hc428a2be;
         8'd144: w = 32'hd48a289c; 8'd145: w = 32'hc20be082; 8'd146: w = 32'hdea28a06;
         8'd147: w = 32'hc853e508; 8'd148: w = 32'he2508522; 8'd149: w = 32'hfe41041e;
         8'd150: w = 32'hfe208206; 8'd151: w = 32'hfe83883e; 8'd152: w = 32'hfe41c41e;
         8'd153: w = 32'hd0a28f82; 8'd154: w = 32'hfe428a3e; 8'd155: w = 32'hd0a28a3e;
         8'd156: w = 32'hdcaaa894; 8'd157: w = 32'hdc89c23e; 8'd158: w = 32'hfe4924ac;
         default: w = 32'h00000000;
      endcase
      return w;
   endfunction

   function automatic logic [15:0] stretch_bits(input logic [7:0] v);
      logic [15:0] r;
      for (int b = 0; b < 8; b++) begin
         r[2*b]   = v[b];
         r[2*b+1] = v[b];
      end
      return r;
   endfunction

endpackage

[hw/rtl/otcr_ctrl.sv]
// ---------------------------------------------------------------------------
// otcr_ctrl
// Sequencer: decodes one transaction and steps glyph columns, spacers and window updates.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module otcr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  otcr_pkg::status_type status,
   output otcr_pkg::cmd_type    cmd,
   output logic                 rsp_last
);
   import otcr_pkg::*;

   state_type state_ff, state_in;
   logic      fire;

   assign fire      = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.action)
               ACT_DRAW:                state_in = ST_COLUMN;
               ACT_NEWLINE, ACT_CURSOR: state_in = ST_WINDOW;
               default:                 state_in = ST_IDLE;
            endcase
         end
         ST_COLUMN: begin
            if (fire && status.rep_last && status.half_last && status.col_last)
               state_in = ST_SPACER;
         end
         ST_SPACER: begin
            if (fire && status.spacer_last) state_in = ST_IDLE;
         end
         ST_WINDOW: begin
            if (fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      rsp_valid = 1'b0;
      rsp_last  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_item = req_valid;
         end
         ST_DECODE: begin
            cmd.load_glyph = (status.action == ACT_DRAW);
            cmd.do_newline = (status.action == ACT_NEWLINE);
            cmd.do_skip    = (status.action == ACT_SKIP);
            cmd.do_flip    = (status.action == ACT_FLIP);
            cmd.do_cursor  = (status.action == ACT_CURSOR);
            cmd.do_invert  = (status.action == ACT_INVERT);
         end
         ST_COLUMN: begin
            rsp_valid       = 1'b1;
            cmd.emit_column = 1'b1;
            cmd.next_rep    = fire;
            cmd.next_col    = fire && status.rep_last && status.half_last;
         end
         ST_SPACER: begin
            rsp_valid        = 1'b1;
            rsp_last         = status.spacer_last;
            cmd.emit_spacer  = 1'b1;
            cmd.next_spacer  = fire;
            cmd.finish_glyph = fire && status.spacer_last;
         end
         ST_WINDOW: begin
            rsp_valid       = 1'b1;
            rsp_last        = 1'b1;
            cmd.emit_window = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   `ASSERT_IMPL(a_no_accept_busy, clock, reset, (state_ff != ST_IDLE) |-> req_stall)
   `ASSERT_IMPL(a_rsp_only_emit, clock, reset,
      rsp_valid |-> (state_ff == ST_COLUMN || state_ff == ST_SPACER || state_ff == ST_WINDOW))
   `ASSERT_IMPL(a_window_done, clock, reset,
      (state_ff == ST_WINDOW && fire) |=> (state_ff == ST_IDLE))

endmodule

[hw/rtl/otcr_dp.sv]
// ---------------------------------------------------------------------------
// otcr_dp
// Datapath: cursor, mask, configuration, glyph word and output byte logic.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module otcr_dp #(
   parameter int GLYPH_COUNT        = otcr_pkg::GLYPH_COUNT_DEF,
   parameter int SCREEN_LAST_COLUMN = otcr_pkg::LAST_COLUMN_DEF,
   parameter int SCREEN_LAST_PAGE   = otcr_pkg::LAST_PAGE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  otcr_pkg::cmd_type    cmd,
   output otcr_pkg::status_type status,
   input  logic [1:0]           req_mode,
   input  logic [7:0]           req_char_code,
   input  logic [7:0]           req_new_column,
   input  logic [7:0]           req_new_page,
   input  logic                 req_invert_on,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [2:0]           csr_data,
   output logic                 rsp_kind,
   output logic [7:0]           rsp_data_byte,
   output logic [6:0]           rsp_window_x0,
   output logic [2:0]           rsp_window_y0,
   output logic [2:0]           rsp_window_y1
);
   import otcr_pkg::*;

   localparam logic [7:0] LAST_COL  = 8'(SCREEN_LAST_COLUMN);
   localparam logic [7:0] LAST_PAGE = 8'(SCREEN_LAST_PAGE);
   localparam logic [7:0] SKIP_COL  = 8'(SCREEN_LAST_COLUMN - 6);

   logic [7:0]  column_ff, column_in;
   logic [7:0]  page_ff, page_in;
   logic [7:0]  mask_ff, mask_in;
   logic [2:0]  scale_ff;
   logic        dbl_ff, wrap_ff;
   logic [1:0]  mode_ff;
   logic [7:0]  code_ff;
   logic [7:0]  ncol_ff, npage_ff;
   logic        inv_ff;
   logic [31:0] glyph_ff;
   logic [2:0]  colidx_ff;
   logic [1:0]  rep_ff;
   logic        half_ff;
   logic [1:0]  sc;
   logic [7:0]  idx;
   logic [7:0]  gidx;
   logic [7:0]  colbyte;
   logic [15:0] tall;
   logic [2:0]  ncols;
   logic [7:0]  y1_full;
   action_type  act;

   always_comb begin
      case (scale_ff)
         3'd0, 3'd1: sc = 2'd0;
         3'd2:       sc = 2'd1;
         3'd3:       sc = 2'd2;
         default:    sc = 2'd3;
      endcase
   end

   always_comb begin
      idx = code_ff - 8'd32;
      if (idx <= 8'd95)       gidx = idx;
      else if (idx <= 8'd111) gidx = idx + 8'd47;
      else                    gidx = idx - 8'd17;
   end

   always_comb begin
      act = ACT_NONE;
      case (mode_ff)
         MODE_CHAR: begin
            if (code_ff > 8'd191)                                 act = ACT_NONE;
            else if (code_ff == 8'd10 || (wrap_ff && column_ff > LAST_COL))
               act = ACT_NEWLINE;
            else if (code_ff == 8'd12)                            act = ACT_FLIP;
            else if (code_ff < 8'd32)                             act = ACT_NONE;
            else if (page_ff > LAST_PAGE)                         act = ACT_NONE;
            else if (wrap_ff && code_ff == 8'd32 && column_ff == 8'd0) act = ACT_NONE;
            else if (column_ff > SKIP_COL)                        act = ACT_SKIP;
            else                                                  act = ACT_DRAW;
         end
         MODE_CURSOR: act = ACT_CURSOR;
         MODE_INVERT: act = ACT_INVERT;
         default:     act = ACT_NONE;
      endcase
   end

   assign ncols   = 3'd1 + {1'b0, glyph_ff[31:30]};
   assign colbyte = {2'b00, glyph_ff[6*colidx_ff +: 6]} ^ mask_ff;
   assign tall    = stretch_bits(colbyte);

   assign status.action      = act;
   assign status.rep_last    = (rep_ff == sc);
   assign status.half_last   = !dbl_ff || half_ff;
   assign status.col_last    = (colidx_ff == ncols);
   assign status.spacer_last = !dbl_ff || half_ff;

   always_comb begin
      column_in = column_ff;
      page_in   = page_ff;
      mask_in   = mask_ff;
      if (cmd.do_newline) begin
         column_in = 8'd0;
         page_in   = page_ff + (dbl_ff ? 8'd2 : 8'd1);
      end
      if (cmd.do_skip)   column_in = column_ff + 8'd6;
      if (cmd.do_flip)   mask_in   = ~mask_ff;
      if (cmd.do_cursor) begin
         column_in = ncol_ff;
         page_in   = npage_ff;
      end
      if (cmd.do_invert) mask_in = {8{inv_ff}};
      if (cmd.next_col) column_in = column_ff + {6'd0, sc} + 8'd1;
      if (cmd.finish_glyph) column_in = column_ff + 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         page_ff   <= '0;
         mask_ff   <= '0;
         scale_ff  <= 3'd1;
         dbl_ff    <= 1'b0;
         wrap_ff   <= 1'b0;
      end else begin
         column_ff <= column_in;
         page_ff   <= page_in;
         mask_ff   <= mask_in;
         if (csr_write) begin
            case (csr_index)
               CSR_WIDTH_SCALE:   scale_ff <= csr_data;
               CSR_DOUBLE_HEIGHT: dbl_ff   <= csr_data[0];
               CSR_AUTO_NEWLINE:  wrap_ff  <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff  <= req_mode;
         code_ff  <= req_char_code;
         ncol_ff  <= req_new_column;
         npage_ff <= req_new_page;
         inv_ff   <= req_invert_on;
      end
      if (cmd.load_glyph) begin
         glyph_ff  <= (int'(gidx) < GLYPH_COUNT && int'(gidx) < ROM_WORDS) ? glyph_rom(gidx)
                                                                          : 32'd0;
         colidx_ff <= 3'd0;
         rep_ff    <= 2'd0;
         half_ff   <= 1'b0;
      end
      if (cmd.next_rep) begin
         if (!dbl_ff || half_ff) begin
            half_ff <= 1'b0;
            if (rep_ff == sc) begin
               rep_ff    <= 2'd0;
               colidx_ff <= colidx_ff + 3'd1;
            end else begin
               rep_ff <= rep_ff + 2'd1;
            end
         end else begin
            half_ff <= 1'b1;
         end
      end
      if (cmd.next_spacer) half_ff <= dbl_ff && !half_ff;
   end

   assign y1_full = page_ff + (dbl_ff ? 8'd1 : 8'd0);

   always_comb begin
      rsp_kind      = KIND_DATA;
      rsp_data_byte = 8'd0;
      rsp_window_x0 = 7'd0;
      rsp_window_y0 = 3'd0;
      rsp_window_y1 = 3'd0;
      if (cmd.emit_column) rsp_data_byte = dbl_ff ? (half_ff ? tall[15:8] : tall[7:0])
                                                  : colbyte;
      if (cmd.emit_spacer) rsp_data_byte = mask_ff;
      if (cmd.emit_window) begin
         rsp_kind      = KIND_WINDOW;
         rsp_window_x0 = 7'((column_ff > LAST_COL) ? LAST_COL : column_ff);
         rsp_window_y0 = 3'((page_ff > LAST_PAGE) ? LAST_PAGE : page_ff);
         rsp_window_y1 = 3'((y1_full > LAST_PAGE) ? LAST_PAGE : y1_full);
      end
   end

   `ASSERT_IMPL(a_one_action, clock, reset,
      $onehot0({cmd.do_newline, cmd.do_skip, cmd.do_flip, cmd.do_cursor, cmd.do_invert}))
   `ASSERT_IMPL(a_col_range, clock, reset, cmd.emit_column |-> (colidx_ff <= ncols))
   `ASSERT_IMPL(a_flip_mask, clock, reset, cmd.do_flip |=> (mask_ff == ~$past(mask_ff)))

endmodule

[hw/rtl/oled_text_column_renderer.sv]
// ---------------------------------------------------------------------------
// oled_text_column_renderer
// Bitmap font text renderer producing panel column bytes and window updates.
// ---------------------------------------------------------------------------
// Usage: the req_ channel takes one transaction per item: render a character,
// set the cursor or set inversion. The rsp_ channel returns pixel column bytes
// (kind 0) or text window updates (kind 1); rsp_last marks the final result
// of an item. Items that cause no result return nothing.
// The csr_ port writes width_scale, double_height and auto_newline, index 0,
// 1, 2 in that order, while the block is idle; the user must keep to this, as
// the block itself does not enforce it. After acceptance the sequencer decodes
// the item, then returns one result per cycle while rsp_ is not stalled. A
// drawn glyph returns up to 42 result bytes (at scale 4 in double height). The
// single sequencer handles one item at a time; one byte leaves per cycle unless rsp_ is stalled.
// Reset clears cursor, invert mask and configuration to their defaults.
// A stalled rsp_ holds its byte and the sequencer waits on it.
// ---------------------------------------------------------------------------
module oled_text_column_renderer #(
   parameter int GLYPH_COUNT        = otcr_pkg::GLYPH_COUNT_DEF,
   parameter int SCREEN_LAST_COLUMN = otcr_pkg::LAST_COLUMN_DEF,
   parameter int SCREEN_LAST_PAGE   = otcr_pkg::LAST_PAGE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_new_column,
   input  logic [7:0] req_new_page,
   input  logic       req_invert_on,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [6:0] rsp_window_x0,
   output logic [2:0] rsp_window_y0,
   output logic [2:0] rsp_window_y1,
   output logic       rsp_last,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [2:0] csr_data
);
   import otcr_pkg::*;

   cmd_type    cmd;
   status_type status;

   otcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .rsp_last  (rsp_last)
   );

   otcr_dp #(
      .GLYPH_COUNT        (GLYPH_COUNT),
      .SCREEN_LAST_COLUMN (SCREEN_LAST_COLUMN),
      .SCREEN_LAST_PAGE   (SCREEN_LAST_PAGE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_mode),
      .req_char_code  (req_char_code),
      .req_new_column (req_new_column),
      .req_new_page   (req_new_page),
      .req_invert_on  (req_invert_on),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_window_x0  (rsp_window_x0),
      .rsp_window_y0  (rsp_window_y0),
      .rsp_window_y1  (rsp_window_y1)
   );

endmodule

[verif/oled_text_column_renderer_checker.sv]
// ----------------------------------------------------------------------------
// Text renderer scoreboard
// Watches the request and response channels of the text column renderer,
// predicts every pixel byte and window update from the accepted requests,
// and compares each response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module oled_text_column_renderer_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_new_column,
   input  logic [7:0] req_new_page,
   input  logic       req_invert_on,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_kind,
   input  logic [7:0] rsp_data_byte,
   input  logic [6:0] rsp_window_x0,
   input  logic [2:0] rsp_window_y0,
   input  logic [2:0] rsp_window_y1,
   input  logic       rsp_last,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [2:0] csr_data,
   output int         fail_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import otcr_pkg::*;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [6:0] x0;
      logic [2:0] y0;
      logic [2:0] y1;
      logic       last;
   } column_out_type;

   column_out_type expected_columns[$];

   logic [7:0] cur_col, cur_page, inv_mask;
   logic [2:0] scale_reg;
   logic       tall, wrap;

   function automatic logic [31:0] font_word(input logic [7:0] idx);
      logic [31:0] t [0:158];
      t = '{
         32'h00000000,32'h00000df7,32'h40007007,32'hd2fd2fd2,32'hc60dec18,32'hf1c8c4e3,
         32'he06e59b8,32'h00000007,32'h4002185e,32'h4001e861,32'h40014214,32'h40008708,
         32'h00000638,32'h40008208,32'h00000618,32'h40003330,32'hde86d85e,32'h8083f880,
         32'he6a69a72,32'hda965852,32'hd0fd2518,32'hd9965963,32'hd0a69a9c,32'hc3159841,
         32'hda96595a,32'hdea69a46,32'h000006db,32'h000006fb,32'h40011284,32'h8028a28a,
         32'h40004291,32'hc7165b41,32'hefa6d87f,32'hfe24927e,32'hfa96597f,32'hd286185e,
         32'hde86187f,32'he186597f,32'hc114517f,32'hd8a6985e,32'hff20823f,32'h40021fe1,
         32'h4003d870,32'hf128413f,32'he082083f,32'hff0840bf,32'hff2040bf,32'hde86185e,
         32'hc624927f,32'hee46985e,32'hf624927f,32'hd2a69952,32'hc107f041,32'hdf82081f,
         32'hc7620607,32'hdf81c81f,32'hf12842b1,32'hc3138103,32'he3965a71,32'h4002187f,
         32'h40030303,32'h4003f861,32'hc4081084,32'hc4210204,32'h40004081,32'hdcaaaa90,
         32'hd892493f,32'hd48a289c,32'hff924918,32'hccaaaa9c,32'h8027e200,32'hdcaaaa84,
         32'hf810413f,32'h00000f40,32'h00000760,32'he250823f,32'h0000081f,32'hfc0bc0be,
         32'hfc0820be,32'hdc8a289c,32'hc428a2bc,32'hfc28a284,32'hc210423e,32'hd2aaaaa4,
         32'h400247c4,32'hde82081e,32'hce42040e,32'hde81881e,32'he2508522,32'hdea28a06,
         32'he6aaaab2,32'h40021ccc,32'h00000fc0,32'h4000cce1,32'h80108108,32'hf85915b8,
         32'hf996597f,32'hfa96597f,32'hc104107f,32'hf07d17b0,32'hf3869a7f,32'hfb11e13b,
         32'hda961852,32'hff08423f,32'hff10943f,32'hf128413f,32'hff042330,32'hff0840bf,
         32'hff10413f,32'hde86185e,32'hff04107f,32'hc624927f,32'hd286185e,32'hc107f041,
         32'hdf924903,32'hde4bf49e,32'hf12842b1,32'hff41041f,32'hff104103,32'hff83e83f,
         32'hff41e41f,32'hd8924fc1,32'hff62493f,32'hd892493f,32'hde965852,32'hff87f23f,
         32'hff249276,32'hfcaaaa90,32'hd0a69a9c,32'hf4aaaabe,32'hc20820be,32'hdcaa9a50,
         32'hccaaaa9c,32'hf621c236,32'hd4aaa894,32'hfe10843e,32'hfe10943e,32'he250823e,
         32'hf0302330,32'hfe10813e,32'hfe20823e,32'hdc8a289c,32'hfe0820be,32'hc428a2be,
         32'hd48a289c,32'hc20be082,32'hdea28a06,32'hc853e508,32'he2508522,32'hfe41041e,
         32'hfe208206,32'hfe83883e,32'hfe41c41e,32'hd0a28f82,32'hfe428a3e,32'hd0a28a3e,
         32'hdcaaa894,32'hdc89c23e,32'hfe4924ac};
      return (idx < 8'd159) ? t[idx] : 32'h0;
   endfunction

   function automatic column_out_type window_entry();
      column_out_type e;
      logic [7:0] y1;
      e = '0;
      e.kind = KIND_WINDOW;
      e.x0 = (cur_col > 8'd127) ? 7'd127 : cur_col[6:0];
      e.y0 = (cur_page > 8'd7) ? 3'd7 : cur_page[2:0];
      y1 = cur_page + (tall ? 8'd1 : 8'd0);
      e.y1 = (y1 > 8'd7) ? 3'd7 : y1[2:0];
      return e;
   endfunction

   function automatic column_out_type byte_entry(input logic [7:0] b);
      column_out_type e;
      e = '0;
      e.kind = KIND_DATA;
      e.data = b;
      return e;
   endfunction

   task automatic predict_glyph(input logic [7:0] c, inout column_out_type outs[$]);
      logic [7:0] idx, colv;
      logic [31:0] bits;
      logic [15:0] wide;
      int sc, ncols;
      idx = c - 8'd32;
      if (idx > 8'd111) idx = idx - 8'd17;
      else if (idx > 8'd95) idx = idx + 8'd47;
      sc = (scale_reg < 3'd1) ? 1 : (scale_reg > 3'd4) ? 4 : int'(scale_reg);
      bits = font_word(idx);
      ncols = 2 + int'(bits[31:30]);
      for (int k = 0; k < ncols; k++) begin
         colv = {2'b00, bits[k*6 +: 6]} ^ inv_mask;
         for (int i = 0; i < 8; i++) begin
            wide[2*i] = colv[i];
            wide[2*i+1] = colv[i];
         end
         for (int t = 0; t < sc; t++) begin
            if (!tall) outs.push_back(byte_entry(colv));
            else begin
               outs.push_back(byte_entry(wide[7:0]));
               outs.push_back(byte_entry(wide[15:8]));
            end
         end
         cur_col = cur_col + sc[7:0];
      end
      outs.push_back(byte_entry(inv_mask));
      if (tall) outs.push_back(byte_entry(inv_mask));
      cur_col = cur_col + 8'd1;
   endtask

   task automatic predict_item();
      column_out_type outs[$];
      logic [7:0] c;
      c = req_char_code;
      if (req_mode == MODE_CHAR) begin
         if (c > 8'd191) begin
         end else if (c == 8'd10 || (wrap && cur_col > 8'd127)) begin
            cur_col = 8'd0;
            cur_page = cur_page + (tall ? 8'd2 : 8'd1);
            outs.push_back(window_entry());
         end else if (c == 8'd12) begin
            inv_mask = ~inv_mask;
         end else if (c < 8'd32 || cur_page > 8'd7) begin
         end else if (wrap && c == 8'd32 && cur_col == 8'd0) begin
         end else if (cur_col > 8'd121) begin
            cur_col = cur_col + 8'd6;
         end else begin
            predict_glyph(c, outs);
         end
      end else if (req_mode == MODE_CURSOR) begin
         cur_col = req_new_column;
         cur_page = req_new_page;
         outs.push_back(window_entry());
      end else if (req_mode == MODE_INVERT) begin
         inv_mask = req_invert_on ? 8'hFF : 8'h00;
      end
      if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
      foreach (outs[i]) expected_columns.push_back(outs[i]);
   endtask

   always @(posedge clock) begin
      column_out_type got, exp_e;
      if (reset) begin
         cur_col = 8'd0;
         cur_page = 8'd0;
         inv_mask = 8'd0;
         scale_reg = 3'd1;
         tall = 1'b0;
         wrap = 1'b0;
         fail_count = 0;
         expected_columns.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_WIDTH_SCALE:   scale_reg = csr_data;
               CSR_DOUBLE_HEIGHT: tall = csr_data[0];
               CSR_AUTO_NEWLINE:  wrap = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_item();
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_kind, rsp_data_byte, rsp_window_x0, rsp_window_y0,
                   rsp_window_y1, rsp_last};
            if (expected_columns.size() == 0) begin
               $display("%0t: unexpected response %h", $realtime, got);
               fail_count++;
            end else begin
               exp_e = expected_columns.pop_front();
               if (got.kind !== exp_e.kind || got.data !== exp_e.data ||
                   got.x0 !== exp_e.x0 || got.y0 !== exp_e.y0 ||
                   got.y1 !== exp_e.y1 || got.last !== exp_e.last) begin
                  $display({"%0t: mismatch expected k%0d d%h x%0d y%0d-%0d l%0d",
                            " actual k%0d d%h x%0d y%0d-%0d l%0d"},
                     $realtime, exp_e.kind, exp_e.data, exp_e.x0, exp_e.y0, exp_e.y1,
                     exp_e.last, got.kind, got.data, got.x0, got.y0, got.y1, got.last);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_columns.size();
   end
endmodule

[verif/oled_text_column_renderer_tb.sv]
// ----------------------------------------------------------------------------
// Text renderer testbench
// Drives characters, cursor moves and inversion requests through several
// configurations and backpressure phases; the checker scores every response.
// ----------------------------------------------------------------------------
module oled_text_column_renderer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import otcr_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_mode = MODE_CHAR;
   logic [7:0] req_char_code = '0, req_new_column = '0, req_new_page = '0;
   logic       req_invert_on = 1'b0;
   logic       rsp_valid, rsp_kind, rsp_last;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_data_byte;
   logic [6:0] rsp_window_x0;
   logic [2:0] rsp_window_y0, rsp_window_y1;
   logic       csr_write = 1'b0;
   logic [1:0] csr_index = CSR_WIDTH_SCALE;
   logic [2:0] csr_data = '0;
   int         fail_count, pending_count;
   int         send_idle_pct = 0, stall_pct = 0;
   int         hold_off = 0;
   longint     cycle_count = 0;

   always #10 clock = ~clock;

   oled_text_column_renderer dut (.*);
   oled_text_column_renderer_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 2_000_000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_item(input logic [1:0] m, input logic [7:0] c,
                            input logic [7:0] col, input logic [7:0] pg, input logic inv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_char_code <= c;
      req_new_column <= col;
      req_new_page <= pg;
      req_invert_on <= inv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [2:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
   endtask

   task automatic drain_and_configure(input logic [2:0] sc, input logic dh, input logic an);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      write_csr(CSR_WIDTH_SCALE, sc);
      write_csr(CSR_DOUBLE_HEIGHT, {2'b00, dh});
      write_csr(CSR_AUTO_NEWLINE, {2'b00, an});
      csr_write <= 1'b0;
   endtask

   task automatic send_random(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 60)
            send_item(MODE_CHAR, 8'($urandom_range(32, 191)), 8'($urandom),
                      8'($urandom), 1'($urandom));
         else if (r < 68)
            send_item(MODE_CHAR, 8'd10, 8'($urandom), 8'($urandom), 1'($urandom));
         else if (r < 72)
            send_item(MODE_CHAR, 8'd12, 8'($urandom), 8'($urandom), 1'($urandom));
         else if (r < 76)
            send_item(MODE_CHAR, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
         else if (r < 88)
            send_item(MODE_CURSOR, 8'($urandom), 8'(($urandom_range(3) == 0) ? $urandom :
                      $urandom_range(127)), 8'(($urandom_range(3) == 0) ? $urandom :
                      $urandom_range(7)), 1'($urandom));
         else if (r < 96)
            send_item(MODE_INVERT, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
         else
            send_item(2'd3, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(MODE_CHAR, 8'd65, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd32, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd126, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd127, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd128, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd191, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd192, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd255, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd0, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd31, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd12, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd87, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd10, 8'd0, 8'd0, 1'b0);
      send_item(MODE_INVERT, 8'd0, 8'd0, 8'd0, 1'b1);
      send_item(MODE_CHAR, 8'd66, 8'd0, 8'd0, 1'b0);
      send_item(MODE_INVERT, 8'd0, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CURSOR, 8'd0, 8'd125, 8'd7, 1'b0);
      send_item(MODE_CHAR, 8'd67, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CURSOR, 8'd0, 8'd255, 8'd255, 1'b0);
      send_item(MODE_CHAR, 8'd68, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd10, 8'd0, 8'd0, 1'b0);
      send_item(2'd3, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_item(MODE_CURSOR, 8'd0, 8'd0, 8'd0, 1'b0);

      drain_and_configure(3'd4, 1'b1, 1'b1);
      send_item(MODE_CHAR, 8'd32, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CHAR, 8'd77, 8'd0, 8'd0, 1'b0);
      send_item(MODE_CURSOR, 8'd0, 8'd200, 8'd6, 1'b0);
      send_item(MODE_CHAR, 8'd65, 8'd0, 8'd0, 1'b0);
      send_random(60);

      drain_and_configure(3'd0, 1'b0, 1'b1);
      send_idle_pct = 55;
      send_random(60);

      drain_and_configure(3'd7, 1'b1, 1'b0);
      send_idle_pct = 0;
      stall_pct = 55;
      send_random(60);

      drain_and_configure(3'd2, 1'b0, 1'b0);
      send_idle_pct = 27;
      stall_pct = 27;
      hold_off = 300;
      send_random(70);

      drain_and_configure(3'd3, 1'b1, 1'b1);
      send_idle_pct = 0;
      stall_pct = 0;
      send_random(60);

      drain_and_configure(3'd1, 1'b0, 1'b1);
      stall_pct = 27;
      send_random(50);

      req_valid <= 1'b0;
      for (int w = 0; w < 100000 && pending_count != 0; w++) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/otcr_pkg.sv
hw/rtl/otcr_ctrl.sv
hw/rtl/otcr_dp.sv
hw/rtl/oled_text_column_renderer.sv
verif/oled_text_column_renderer_checker.sv
verif/oled_text_column_renderer_tb.sv
